// File: rtl/rlac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlac_pkg
// Shared codes, reset values and types of the room light and alarm controller.
// ----------------------------------------------------------------------------
package rlac_pkg;

    // command codes
    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_MANUAL    = 2'd1;
    localparam logic [1:0] CMD_EMERGENCY = 2'd2;
    localparam logic [1:0] CMD_SET_MODE  = 2'd3;

    // lamp modes
    localparam logic [2:0] LAMP_OFF       = 3'd0;
    localparam logic [2:0] LAMP_LIGHTING  = 3'd1;
    localparam logic [2:0] LAMP_WARNING   = 3'd2;
    localparam logic [2:0] LAMP_EMERGENCY = 3'd3;
    localparam logic [2:0] LAMP_NORMAL    = 3'd4;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_MS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_G_TEMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_G_HUMID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_S_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_S_HUMID   = 3'd5;

    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 32;
    localparam int TEMP_W     = 12;
    localparam int HUMID_W    = 10;

    // reset values; times in milliseconds, thresholds in tenths of a unit
    localparam logic [TIME_W-1:0]         RST_LOCK_MS = 32'd30000;
    localparam logic [TIME_W-1:0]         RST_HOLD_MS = 32'd30000;
    localparam logic signed [TEMP_W-1:0]  RST_G_TEMP  = 12'sd300;
    localparam logic [HUMID_W-1:0]        RST_G_HUMID = 10'd600;
    localparam logic signed [TEMP_W-1:0]  RST_S_TEMP  = 12'sd350;
    localparam logic [HUMID_W-1:0]        RST_S_HUMID = 10'd700;

    typedef struct packed {
        logic [TIME_W-1:0]        lock_ms;
        logic [TIME_W-1:0]        hold_ms;
        logic signed [TEMP_W-1:0] g_temp;
        logic [HUMID_W-1:0]       g_humid;
        logic signed [TEMP_W-1:0] s_temp;
        logic [HUMID_W-1:0]       s_humid;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [TIME_W-1:0]        now_ms;
        logic [2:0]               mode_value;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUMID_W-1:0]       humidity;
        logic                     motion;
    } item_t;

    typedef struct packed {
        logic [2:0] lamp_mode;
        logic       alarm_on;
        logic       lamp_changed;
        logic       alarm_changed;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/rlac_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlac_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rlac_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [rlac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rlac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output rlac_pkg::cfg_t                         cfg
);

    rlac_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lock_ms <= rlac_pkg::RST_LOCK_MS;
            cfg_reg.hold_ms <= rlac_pkg::RST_HOLD_MS;
            cfg_reg.g_temp  <= rlac_pkg::RST_G_TEMP;
            cfg_reg.g_humid <= rlac_pkg::RST_G_HUMID;
            cfg_reg.s_temp  <= rlac_pkg::RST_S_TEMP;
            cfg_reg.s_humid <= rlac_pkg::RST_S_HUMID;
        end else if (cfg_we) begin
            case (cfg_index)
                rlac_pkg::REG_LOCK_MS: cfg_reg.lock_ms <= cfg_wdata;
                rlac_pkg::REG_HOLD_MS: cfg_reg.hold_ms <= cfg_wdata;
                rlac_pkg::REG_G_TEMP:  cfg_reg.g_temp  <= cfg_wdata[rlac_pkg::TEMP_W-1:0];
                rlac_pkg::REG_G_HUMID: cfg_reg.g_humid <= cfg_wdata[rlac_pkg::HUMID_W-1:0];
                rlac_pkg::REG_S_TEMP:  cfg_reg.s_temp  <= cfg_wdata[rlac_pkg::TEMP_W-1:0];
                rlac_pkg::REG_S_HUMID: cfg_reg.s_humid <= cfg_wdata[rlac_pkg::HUMID_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: rtl/rlac_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlac_core
// Controller state and the single-pass decision logic for one word.
// ----------------------------------------------------------------------------
module rlac_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire rlac_pkg::item_t item,
    input  wire rlac_pkg::cfg_t  cfg,
    output rlac_pkg::result_t result
);

    logic [2:0]                  lamp_reg, lamp_next;
    logic                        alarm_reg, alarm_next;
    logic                        sentinel_reg, sentinel_next;
    logic [rlac_pkg::TIME_W-1:0] lock_until_reg, lock_until_next;
    logic [rlac_pkg::TIME_W-1:0] last_motion_reg, last_motion_next;
    logic                        light_reg, light_next;

    logic [rlac_pkg::TIME_W-1:0] since_motion;
    logic                        locked;
    logic                        g_over;
    logic                        s_over;
    logic [2:0]                  auto_lamp;
    logic                        auto_alarm;
    logic                        lamp_ch;
    logic                        alarm_ch;

    assign since_motion = item.now_ms - last_motion_reg;
    assign locked = item.now_ms < lock_until_reg;
    assign g_over = (item.temperature > cfg.g_temp) || (item.humidity > cfg.g_humid);
    assign s_over = (item.temperature > cfg.s_temp) || (item.humidity > cfg.s_humid);

    always_comb begin
        lamp_next        = lamp_reg;
        alarm_next       = alarm_reg;
        sentinel_next    = sentinel_reg;
        lock_until_next  = lock_until_reg;
        last_motion_next = last_motion_reg;
        light_next       = light_reg;
        auto_lamp        = rlac_pkg::LAMP_OFF;
        auto_alarm       = 1'b0;
        lamp_ch          = 1'b0;
        alarm_ch         = 1'b0;
        case (item.cmd)
            rlac_pkg::CMD_MANUAL: begin
                if (item.mode_value <= rlac_pkg::LAMP_NORMAL) begin
                    lamp_next       = item.mode_value;
                    lock_until_next = item.now_ms + cfg.lock_ms;
                    alarm_next      = (item.mode_value == rlac_pkg::LAMP_EMERGENCY);
                    lamp_ch         = 1'b1;
                    alarm_ch        = 1'b1;
                end
            end
            rlac_pkg::CMD_EMERGENCY: begin
                lamp_next  = rlac_pkg::LAMP_EMERGENCY;
                alarm_next = 1'b1;
                lamp_ch    = 1'b1;
                alarm_ch   = 1'b1;
            end
            rlac_pkg::CMD_SET_MODE: begin
                sentinel_next    = (item.mode_value != 3'd0);
                alarm_next       = 1'b0;
                lamp_next        = rlac_pkg::LAMP_OFF;
                lock_until_next  = '0;
                last_motion_next = '0;
                light_next       = 1'b0;
                lamp_ch          = 1'b1;
                alarm_ch         = 1'b1;
            end
            default: begin
                if (!locked) begin
                    if (!sentinel_reg) begin
                        if (item.motion) begin
                            auto_lamp        = rlac_pkg::LAMP_LIGHTING;
                            last_motion_next = item.now_ms;
                            light_next       = 1'b1;
                        end else if (g_over) begin
                            auto_lamp  = rlac_pkg::LAMP_WARNING;
                            auto_alarm = 1'b1;
                            light_next = 1'b0;
                        end else if (light_reg && (since_motion < cfg.hold_ms)) begin
                            auto_lamp = rlac_pkg::LAMP_LIGHTING;
                        end else begin
                            auto_lamp  = rlac_pkg::LAMP_OFF;
                            light_next = 1'b0;
                        end
                    end else begin
                        if (item.motion) begin
                            auto_lamp  = rlac_pkg::LAMP_EMERGENCY;
                            auto_alarm = 1'b1;
                        end else if (s_over) begin
                            auto_lamp = rlac_pkg::LAMP_WARNING;
                        end else begin
                            auto_lamp = rlac_pkg::LAMP_NORMAL;
                        end
                    end
                    lamp_next  = auto_lamp;
                    alarm_next = auto_alarm;
                    lamp_ch    = (auto_lamp != lamp_reg);
                    alarm_ch   = (auto_alarm != alarm_reg);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_reg        <= rlac_pkg::LAMP_OFF;
            alarm_reg       <= 1'b0;
            sentinel_reg    <= 1'b0;
            lock_until_reg  <= '0;
            last_motion_reg <= '0;
            light_reg       <= 1'b0;
        end else if (advance) begin
            lamp_reg        <= lamp_next;
            alarm_reg       <= alarm_next;
            sentinel_reg    <= sentinel_next;
            lock_until_reg  <= lock_until_next;
            last_motion_reg <= last_motion_next;
            light_reg       <= light_next;
        end
    end

    assign result.lamp_mode     = lamp_next;
    assign result.alarm_on      = alarm_next;
    assign result.lamp_changed  = lamp_ch;
    assign result.alarm_changed = alarm_ch;

endmodule
`default_nettype wire

// File: rtl/room_light_alarm_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// room_light_alarm_controller
// Structure: input register, one pass of decision logic against the state
// registers, result register. Throughput: one word per cycle while the result
// register is not held by m_tready back-pressure.
// Reset: synchronous active-low aresetn clears both stages, the lamp, alarm and
// sentinel state, lockout, motion time, light flag, and loads register defaults.
// ----------------------------------------------------------------------------
module room_light_alarm_controller (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rlac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rlac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // now_ms[31:0], mode_value[34:32], temperature[46:35], humidity[56:47],
    // motion[57], zero[63:58]
    input  wire logic [63:0]                     s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // lamp_mode[2:0], alarm_on[3], lamp_changed[4], alarm_changed[5], zero[7:6]
    output logic [7:0]                           m_tdata
);

    rlac_pkg::cfg_t    cfg;
    rlac_pkg::item_t   item_reg;
    rlac_pkg::result_t result;
    rlac_pkg::result_t res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    rlac_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rlac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.cmd         <= s_tuser;
            item_reg.now_ms      <= s_tdata[31:0];
            item_reg.mode_value  <= s_tdata[34:32];
            item_reg.temperature <= s_tdata[46:35];
            item_reg.humidity    <= s_tdata[56:47];
            item_reg.motion      <= s_tdata[57];
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.alarm_changed, res_reg.lamp_changed,
                       res_reg.alarm_on, res_reg.lamp_mode};

endmodule
`default_nettype wire
